### sv/tlj_pkg.sv
// tlj_pkg: shared types, character codes and defaults for the text line joiner
// used by tlj_ctrl, tlj_dp and text_line_joiner; depends on nothing
package tlj_pkg;

  // default sizes
  localparam int unsigned RunMaxDefault     = 31;
  localparam int unsigned LengthBitsDefault = 16;

  // fixed register and field widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned SmallW   = 5;
  localparam int unsigned MinLenW  = 16;
  localparam int unsigned EmitW    = 6;   // capped run plus page breaks, up to 62

  // character codes
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChPct   = 8'h25;

  // operation codes
  localparam logic OpText = 1'b0;
  localparam logic OpEnd  = 1'b1;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMPTY_ALLOW = 3'd0,
    CFG_MIN_LEN     = 3'd1,
    CFG_NL_LIMIT    = 3'd2,
    CFG_PAGE_BREAK  = 3'd3,
    CFG_PUNCT_MODE  = 3'd4
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LF,
    ST_SPACE,
    ST_BYTE,
    ST_END
  } state_e;

  // output byte source
  typedef enum logic [1:0] {
    SEL_LF,
    SEL_SPACE,
    SEL_BYTE
  } out_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     lf_step;
    out_sel_e sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic op_end;
    logic newline;
    logic emit_lf;
    logic emit_space;
    logic lf_last;
  } sts_t;

  // a character after which a broken line is expected to continue
  function automatic logic expects_continuation(input logic [7:0] c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h61 && c <= 8'h7A) || c == ChComma || c == ChSemi || c == ChPct;
    return r;
  endfunction

endpackage

### sv/text_line_joiner.sv
// text_line_joiner: top level, joins lines broken by a fixed-width formatter
// depends on tlj_pkg, tlj_ctrl and tlj_dp
//
// Bytes enter one transaction at a time; LF and CR runs are counted silently and, at
// the next other byte, closed either with one space (or nothing before a space) or
// with a capped number of LFs plus page-break LFs, then the byte is echoed. A newline
// byte gives no result; a plain byte gives only its echo, and a new byte can be taken
// as that echo leaves. A byte that closes a run gives one space or none for a join and
// otherwise the emitted LFs (up to 62) before its echo. An end item gives a single LF.
// The controller sends every result through one output stage, one byte per cycle
// while out_ready_i is high.
module text_line_joiner #(
  parameter int unsigned RUN_MAX     = tlj_pkg::RunMaxDefault,
  parameter int unsigned LENGTH_BITS = tlj_pkg::LengthBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlj_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tlj_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [7:0]                    text_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_of_run_o,
  output logic                          end_of_text_o
);
  import tlj_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  tlj_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .last_of_run_o (last_of_run_o),
    .end_of_text_o (end_of_text_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // counters, decision and output byte
  tlj_dp #(
    .RUN_MAX     (RUN_MAX),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .operation_i (operation_i),
    .text_byte_i (text_byte_i),
    .out_byte_o  (out_byte_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // end flag always rides on the closing LF
  a_end_is_last_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_of_text_o) |-> (last_of_run_o && (out_byte_o == ChLf)))
    else $error("end of text not on a final LF");

  // an accepted end item is answered in the next cycle
  a_end_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == OpEnd)) |=>
    (out_valid_o && end_of_text_o))
    else $error("end item not answered");

  // a newline byte gives no result
  a_newline_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == OpText) &&
     ((text_byte_i == ChLf) || (text_byte_i == ChCr))) |=> !out_valid_o)
    else $error("newline byte produced output");

  // no new input while an inner result is pending
  a_ready_only_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_of_run_o) |-> !in_ready_o)
    else $error("input taken before item finished");
`endif

endmodule

### sv/tlj_ctrl.sv
// tlj_ctrl: sequencing state machine for the text line joiner
// depends on tlj_pkg
module tlj_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          last_of_run_o,
  output logic          end_of_text_o,
  input  tlj_pkg::sts_t sts_i,
  output tlj_pkg::cmd_t cmd_o
);
  import tlj_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  // input is taken when idle or when the final result of an item leaves
  assign in_ready_o = (state_q == ST_IDLE) ||
                      (((state_q == ST_BYTE) || (state_q == ST_END)) && out_ready_i);
  assign accept = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_LF: begin
        if (out_ready_i) begin
          state_d = sts_i.lf_last ? ST_BYTE : ST_LF;
        end
      end
      ST_SPACE: begin
        if (out_ready_i) state_d = ST_BYTE;
      end
      ST_BYTE: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      ST_END: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (accept) begin
      if (sts_i.op_end) begin
        state_d = ST_END;
      end else if (sts_i.newline) begin
        state_d = ST_IDLE;
      end else if (sts_i.emit_lf) begin
        state_d = ST_LF;
      end else if (sts_i.emit_space) begin
        state_d = ST_SPACE;
      end else begin
        state_d = ST_BYTE;
      end
    end
  end

  // outputs and commands
  always_comb begin
    cmd_o.load    = accept;
    cmd_o.lf_step = 1'b0;
    cmd_o.sel     = SEL_BYTE;
    out_valid_o   = 1'b0;
    last_of_run_o = 1'b0;
    end_of_text_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        out_valid_o = 1'b0;
      end
      ST_LF: begin
        out_valid_o   = 1'b1;
        cmd_o.sel     = SEL_LF;
        cmd_o.lf_step = out_ready_i;
      end
      ST_SPACE: begin
        out_valid_o = 1'b1;
        cmd_o.sel   = SEL_SPACE;
      end
      ST_BYTE: begin
        out_valid_o   = 1'b1;
        last_of_run_o = 1'b1;
      end
      ST_END: begin
        out_valid_o   = 1'b1;
        cmd_o.sel     = SEL_LF;
        last_of_run_o = 1'b1;
        end_of_text_o = 1'b1;
      end
      default: begin
        out_valid_o = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/tlj_dp.sv
// tlj_dp: registers, run counters, join decision and output byte for the line joiner
// depends on tlj_pkg
module tlj_dp #(
  parameter int unsigned RUN_MAX     = tlj_pkg::RunMaxDefault,
  parameter int unsigned LENGTH_BITS = tlj_pkg::LengthBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlj_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tlj_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          operation_i,
  input  logic [7:0]                    text_byte_i,
  output logic [7:0]                    out_byte_o,
  input  tlj_pkg::cmd_t                 cmd_i,
  output tlj_pkg::sts_t                 sts_o
);
  import tlj_pkg::*;

  localparam int unsigned RunW = $clog2(RUN_MAX + 1);
  localparam int unsigned CmpW = (LENGTH_BITS > MinLenW) ? LENGTH_BITS : MinLenW;
  localparam logic [RunW-1:0] RunSat = RunW'(RUN_MAX);

  // configuration registers
  logic [SmallW-1:0]  empty_allow_q;
  logic [MinLenW-1:0] min_len_q;
  logic [SmallW-1:0]  nl_limit_q;
  logic [SmallW-1:0]  page_break_q;
  logic               punct_mode_q;

  // text state
  logic [RunW-1:0]        lf_run_q, lf_run_d;
  logic [RunW-1:0]        cr_run_q, cr_run_d;
  logic [LENGTH_BITS-1:0] line_len_q, line_len_d;
  logic [7:0]             last_char_q, last_char_d;
  logic [7:0]             byte_q;
  logic [EmitW-1:0]       lf_left_q, lf_left_d;

  logic                   is_lf, is_cr, is_end;
  logic [RunW-1:0]        count;
  logic [EmitW-1:0]       count_x, allow_x, limit_x, capped;
  logic                   join_ok;

  // config writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_allow_q <= '0;
      min_len_q     <= '0;
      nl_limit_q    <= '0;
      page_break_q  <= '0;
      punct_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_EMPTY_ALLOW: empty_allow_q <= cfg_wdata_i[SmallW-1:0];
        CFG_MIN_LEN:     min_len_q     <= cfg_wdata_i[MinLenW-1:0];
        CFG_NL_LIMIT:    nl_limit_q    <= cfg_wdata_i[SmallW-1:0];
        CFG_PAGE_BREAK:  page_break_q  <= cfg_wdata_i[SmallW-1:0];
        CFG_PUNCT_MODE:  punct_mode_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input decode
  assign is_end = (operation_i == OpEnd);
  assign is_lf  = (text_byte_i == ChLf);
  assign is_cr  = (text_byte_i == ChCr);

  // run close decision
  assign count   = (lf_run_q != '0) ? lf_run_q : cr_run_q;
  assign count_x = EmitW'(count);
  assign allow_x = EmitW'(empty_allow_q) + EmitW'(1);
  assign limit_x = EmitW'(nl_limit_q);
  assign join_ok = (count_x <= allow_x) &&
                   (CmpW'(line_len_q) >= CmpW'(min_len_q)) &&
                   (!punct_mode_q || expects_continuation(last_char_q));
  assign capped  = ((nl_limit_q != '0) && (count_x > limit_x)) ? limit_x : count_x;

  assign sts_o.op_end     = is_end;
  assign sts_o.newline    = is_lf || is_cr;
  assign sts_o.emit_lf    = (count != '0) && !join_ok;
  assign sts_o.emit_space = (count != '0) && join_ok && (text_byte_i != ChSp);
  assign sts_o.lf_last    = (lf_left_q == EmitW'(1));

  // state update on an accepted item; LF count-down as each LF is taken
  always_comb begin
    lf_run_d    = lf_run_q;
    cr_run_d    = cr_run_q;
    line_len_d  = line_len_q;
    last_char_d = last_char_q;
    lf_left_d   = lf_left_q;
    if (cmd_i.lf_step) lf_left_d = lf_left_q - EmitW'(1);
    if (cmd_i.load) begin
      if (is_end) begin
        lf_run_d    = '0;
        cr_run_d    = '0;
        line_len_d  = '0;
        last_char_d = '0;
      end else if (is_lf) begin
        if (lf_run_q != RunSat) lf_run_d = lf_run_q + RunW'(1);
      end else if (is_cr) begin
        if (cr_run_q != RunSat) cr_run_d = cr_run_q + RunW'(1);
      end else begin
        if (count != '0) begin
          lf_run_d   = '0;
          cr_run_d   = '0;
          line_len_d = LENGTH_BITS'(1);
          lf_left_d  = capped + EmitW'(page_break_q);
        end else if (line_len_q != '1) begin
          line_len_d = line_len_q + LENGTH_BITS'(1);
        end
        if ((text_byte_i != ChSp) && (text_byte_i != ChTab)) last_char_d = text_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lf_run_q    <= '0;
      cr_run_q    <= '0;
      line_len_q  <= '0;
      last_char_q <= '0;
      lf_left_q   <= '0;
    end else begin
      lf_run_q    <= lf_run_d;
      cr_run_q    <= cr_run_d;
      line_len_q  <= line_len_d;
      last_char_q <= last_char_d;
      lf_left_q   <= lf_left_d;
    end
  end

  // held byte for echo
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) byte_q <= text_byte_i;
  end

  // output byte mux
  always_comb begin
    case (cmd_i.sel)
      SEL_LF:    out_byte_o = ChLf;
      SEL_SPACE: out_byte_o = ChSp;
      SEL_BYTE:  out_byte_o = byte_q;
      default:   out_byte_o = byte_q;
    endcase
  end

endmodule
